FILE: rtl/alc_pkg.sv
// Package: shared types, constants and codes of the access lock controller.
`default_nettype none

package alc_pkg;

  // Fixed sizes.
  localparam int unsigned CodeBytes      = 19;
  localparam int unsigned CodeIdxW       = $clog2(CodeBytes);
  localparam int unsigned LenW           = 5;
  localparam int unsigned MaxEntry       = 19;
  localparam int unsigned PressesNeeded  = 3;
  localparam int unsigned PressW         = $clog2(PressesNeeded + 1);
  localparam int unsigned BlinkHalfMs    = 50;
  localparam int unsigned BlinkW         = $clog2(BlinkHalfMs + 1);
  localparam int unsigned TicksPerSecond = 1000;
  localparam int unsigned LockMsW        = $clog2(TicksPerSecond + 1);
  localparam int unsigned CfgIdxW        = 3;
  localparam int unsigned CfgDataW       = 64;
  localparam int unsigned FailMax        = 15;

  localparam logic [7:0] CharCr   = 8'h0D;
  localparam logic [7:0] CharNull = 8'h00;

  typedef enum logic [1:0] {
    OpChar   = 2'd0,
    OpTick   = 2'd1,
    OpPress  = 2'd2,
    OpLogout = 2'd3
  } op_e;

  // Mode state machine, one-hot.
  typedef enum logic [3:0] {
    ModeCode   = 4'b0001,
    ModeButton = 4'b0010,
    ModeAuth   = 4'b0100,
    ModeLocked = 4'b1000
  } mode_e;

  localparam logic [1:0] ModeOutCode   = 2'd0;
  localparam logic [1:0] ModeOutButton = 2'd1;
  localparam logic [1:0] ModeOutAuth   = 2'd2;
  localparam logic [1:0] ModeOutLocked = 2'd3;

  typedef enum logic [3:0] {
    EvNone        = 4'd0,
    EvDenied      = 4'd1,
    EvTooLong     = 4'd2,
    EvConfirmAsk  = 4'd3,
    EvConfirmFail = 4'd4,
    EvGranted     = 4'd5,
    EvLocked      = 4'd6,
    EvUnlocked    = 4'd7,
    EvLoggedOut   = 4'd8
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegCodeLow    = 3'd0,
    RegCodeMid    = 3'd1,
    RegCodeHigh   = 3'd2,
    RegCodeLength = 3'd3,
    RegFailLimit  = 3'd4,
    RegLockSecs   = 3'd5,
    RegConfirmWin = 3'd6,
    RegDebounce   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [CodeBytes-1:0][7:0] code;
    logic [LenW-1:0]           len_eff;
    logic [3:0]                fail_limit;
    logic [7:0]                lock_secs;
    logic [15:0]               confirm_win;
    logic [15:0]               debounce;
  } cfg_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       echo_star;
    logic [3:0] event_res;
    logic [3:0] failure_count;
    logic       led_level;
    logic [7:0] seconds_left;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/alc_in_if.sv
// Interface: input item channel.
`default_nettype none

interface alc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] char_code;

  modport source (output valid, operation, char_code, input ready);
  modport sink (input valid, operation, char_code, output ready);
endinterface

`default_nettype wire

FILE: rtl/alc_out_if.sv
// Interface: result item channel.
`default_nettype none

interface alc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic       echo_star;
  logic [3:0] event_res;
  logic [3:0] failure_count;
  logic       led_level;
  logic [7:0] seconds_left;

  modport source (output valid, mode, echo_star, event_res, failure_count, led_level,
                  seconds_left, input ready);
  modport sink (input valid, mode, echo_star, event_res, failure_count, led_level,
                seconds_left, output ready);
endinterface

`default_nettype wire

FILE: rtl/alc_cfg_if.sv
// Interface: configuration write channel.
`default_nettype none

interface alc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/alc_cfg_regs.sv
// Configuration registers and effective code length.
`default_nettype none

module alc_cfg_regs
  import alc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                wr_i,
  input  wire logic [CfgIdxW-1:0]  idx_i,
  input  wire logic [CfgDataW-1:0] data_i,
  output cfg_t                     cfg_o
);

  logic [63:0] code_low_q, code_mid_q;
  logic [23:0] code_high_q;
  logic [4:0]  code_len_q;
  logic [3:0]  fail_limit_q;
  logic [7:0]  lock_secs_q;
  logic [15:0] confirm_win_q;
  logic [15:0] debounce_q;

  logic [CodeBytes*8-1:0] code_flat;
  logic [LenW-1:0]        len_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_low_q    <= '0;
      code_mid_q    <= '0;
      code_high_q   <= '0;
      code_len_q    <= 5'd12;
      fail_limit_q  <= 4'd3;
      lock_secs_q   <= 8'd30;
      confirm_win_q <= 16'd10000;
      debounce_q    <= 16'd200;
    end else if (wr_i) begin
      case (cfg_reg_e'(idx_i))
        RegCodeLow:    code_low_q    <= data_i;
        RegCodeMid:    code_mid_q    <= data_i;
        RegCodeHigh:   code_high_q   <= data_i[23:0];
        RegCodeLength: code_len_q    <= data_i[4:0];
        RegFailLimit:  fail_limit_q  <= data_i[3:0];
        RegLockSecs:   lock_secs_q   <= data_i[7:0];
        RegConfirmWin: confirm_win_q <= data_i[15:0];
        RegDebounce:   debounce_q    <= data_i[15:0];
        default: ;
      endcase
    end
  end

  assign code_flat = {code_high_q, code_mid_q, code_low_q};

  // Code ends at its first zero byte; bytes past the stored ones read as zero.
  always_comb begin
    if (code_len_q > LenW'(CodeBytes)) begin
      len_eff = LenW'(CodeBytes);
    end else begin
      len_eff = code_len_q;
    end
    for (int i = CodeBytes - 1; i >= 0; i--) begin
      if ((LenW'(i) < code_len_q) && (code_flat[8*i +: 8] == CharNull)) begin
        len_eff = LenW'(i);
      end
    end
  end

  always_comb begin
    cfg_o.code        = code_flat;
    cfg_o.len_eff     = len_eff;
    cfg_o.fail_limit  = fail_limit_q;
    cfg_o.lock_secs   = lock_secs_q;
    cfg_o.confirm_win = confirm_win_q;
    cfg_o.debounce    = debounce_q;
  end

endmodule

`default_nettype wire

FILE: rtl/alc_core.sv
// Lock state and single-pass update for one item.
`default_nettype none

module alc_core
  import alc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [1:0] op_i,
  input  wire logic [7:0] char_i,
  input  cfg_t            cfg_i,
  output result_t         res_o
);

  mode_e               mode_q, mode_d;
  logic [LenW-1:0]     entry_q, entry_d;
  logic [LenW-1:0]     cmp_len_q, cmp_len_d;
  logic                zero_q, zero_d;
  logic                mism_q, mism_d;
  logic [3:0]          fail_q, fail_d;
  logic [PressW-1:0]   press_q, press_d;
  logic [15:0]         since_q, since_d;
  logic [15:0]         confirm_q, confirm_d;
  logic [LockMsW-1:0]  lock_ms_q, lock_ms_d;
  logic [7:0]          lock_secs_q, lock_secs_d;
  logic [BlinkW-1:0]   blink_q, blink_d;
  logic                led_q, led_d;

  logic                star;
  event_e              ev;
  logic                fail_req;
  event_e              fail_ev;
  logic [LenW-1:0]     chk_len;
  logic [7:0]          code_at;
  logic [LockMsW-1:0]  ms_n;
  logic [7:0]          secs_n;
  logic [BlinkW-1:0]   blink_n;
  logic [PressW-1:0]   press_n;
  logic [3:0]          fail_n;
  logic [1:0]          mode_out;

  assign code_at = (entry_q < LenW'(CodeBytes)) ? cfg_i.code[entry_q[CodeIdxW-1:0]] : CharNull;
  assign chk_len = zero_q ? cmp_len_q : entry_q;

  always_comb begin
    mode_d      = mode_q;
    entry_d     = entry_q;
    cmp_len_d   = cmp_len_q;
    zero_d      = zero_q;
    mism_d      = mism_q;
    fail_d      = fail_q;
    press_d     = press_q;
    since_d     = since_q;
    confirm_d   = confirm_q;
    lock_ms_d   = lock_ms_q;
    lock_secs_d = lock_secs_q;
    blink_d     = blink_q;
    led_d       = led_q;
    star        = 1'b0;
    ev          = EvNone;
    fail_req    = 1'b0;
    fail_ev     = EvNone;
    ms_n        = '0;
    secs_n      = lock_secs_q;
    blink_n     = '0;
    press_n     = press_q;
    fail_n      = fail_q;

    case (op_e'(op_i))
      OpChar: begin
        if (mode_q == ModeCode) begin
          if (char_i == CharCr) begin
            if (!mism_q && (chk_len == cfg_i.len_eff)) begin
              entry_d   = '0;
              cmp_len_d = '0;
              zero_d    = 1'b0;
              mism_d    = 1'b0;
              mode_d    = ModeButton;
              press_d   = '0;
              since_d   = '0;
              confirm_d = '0;
              ev        = EvConfirmAsk;
            end else begin
              fail_req = 1'b1;
              fail_ev  = EvDenied;
            end
          end else if (entry_q < LenW'(MaxEntry)) begin
            if (!zero_q) begin
              if (char_i == CharNull) begin
                zero_d    = 1'b1;
                cmp_len_d = entry_q;
              end else if ((entry_q >= cfg_i.len_eff) || (char_i != code_at)) begin
                mism_d = 1'b1;
              end
            end
            entry_d = entry_q + LenW'(1);
            star    = 1'b1;
          end else begin
            fail_req = 1'b1;
            fail_ev  = EvTooLong;
          end
        end
      end
      OpTick: begin
        if (since_q != 16'hFFFF) begin
          since_d = since_q + 16'd1;
        end
        if (mode_q == ModeButton) begin
          if (confirm_q != 16'hFFFF) begin
            confirm_d = confirm_q + 16'd1;
          end
          if (confirm_d >= cfg_i.confirm_win) begin
            fail_req = 1'b1;
            fail_ev  = EvConfirmFail;
          end
        end else if (mode_q == ModeLocked) begin
          ms_n = lock_ms_q + LockMsW'(1);
          if (ms_n >= LockMsW'(TicksPerSecond)) begin
            ms_n = '0;
            if (lock_secs_q != 8'd0) begin
              secs_n = lock_secs_q - 8'd1;
            end
          end
          lock_ms_d   = ms_n;
          lock_secs_d = secs_n;
          if (secs_n == 8'd0) begin
            mode_d    = ModeCode;
            fail_d    = '0;
            entry_d   = '0;
            cmp_len_d = '0;
            zero_d    = 1'b0;
            mism_d    = 1'b0;
            led_d     = 1'b0;
            blink_d   = '0;
            lock_ms_d = '0;
            ev        = EvUnlocked;
          end else begin
            blink_n = blink_q + BlinkW'(1);
            if (blink_n >= BlinkW'(BlinkHalfMs)) begin
              blink_n = '0;
              led_d   = ~led_q;
            end
            blink_d = blink_n;
          end
        end
      end
      OpPress: begin
        if (since_q >= cfg_i.debounce) begin
          since_d = '0;
          if (mode_q == ModeButton) begin
            if (press_q < PressW'(PressesNeeded)) begin
              press_n = press_q + PressW'(1);
            end
            press_d = press_n;
            if (press_n >= PressW'(PressesNeeded)) begin
              mode_d = ModeAuth;
              ev     = EvGranted;
            end
          end
        end
      end
      OpLogout: begin
        if (mode_q == ModeAuth) begin
          mode_d    = ModeCode;
          entry_d   = '0;
          cmp_len_d = '0;
          zero_d    = 1'b0;
          mism_d    = 1'b0;
          ev        = EvLoggedOut;
        end
      end
      default: ;
    endcase

    // Failure: count (saturating), clear the entry, lock at the limit.
    if (fail_req) begin
      if (fail_q != 4'(FailMax)) begin
        fail_n = fail_q + 4'd1;
      end
      fail_d    = fail_n;
      entry_d   = '0;
      cmp_len_d = '0;
      zero_d    = 1'b0;
      mism_d    = 1'b0;
      if (fail_n < cfg_i.fail_limit) begin
        mode_d = ModeCode;
        ev     = fail_ev;
      end else begin
        mode_d      = ModeLocked;
        lock_secs_d = (cfg_i.lock_secs != 8'd0) ? cfg_i.lock_secs : 8'd1;
        lock_ms_d   = '0;
        blink_d     = '0;
        led_d       = 1'b0;
        ev          = EvLocked;
      end
    end
  end

  always_comb begin
    case (mode_d)
      ModeCode:   mode_out = ModeOutCode;
      ModeButton: mode_out = ModeOutButton;
      ModeAuth:   mode_out = ModeOutAuth;
      ModeLocked: mode_out = ModeOutLocked;
      default:    mode_out = ModeOutCode;
    endcase
  end

  always_comb begin
    res_o.mode          = mode_out;
    res_o.echo_star     = star;
    res_o.event_res     = ev;
    res_o.failure_count = fail_d;
    res_o.led_level     = led_d;
    res_o.seconds_left  = (mode_d == ModeLocked) ? lock_secs_d : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeCode;
      entry_q     <= '0;
      cmp_len_q   <= '0;
      zero_q      <= 1'b0;
      mism_q      <= 1'b0;
      fail_q      <= '0;
      press_q     <= '0;
      since_q     <= '0;
      confirm_q   <= '0;
      lock_ms_q   <= '0;
      lock_secs_q <= '0;
      blink_q     <= '0;
      led_q       <= 1'b0;
    end else if (step_i) begin
      mode_q      <= mode_d;
      entry_q     <= entry_d;
      cmp_len_q   <= cmp_len_d;
      zero_q      <= zero_d;
      mism_q      <= mism_d;
      fail_q      <= fail_d;
      press_q     <= press_d;
      since_q     <= since_d;
      confirm_q   <= confirm_d;
      lock_ms_q   <= lock_ms_d;
      lock_secs_q <= lock_secs_d;
      blink_q     <= blink_d;
      led_q       <= led_d;
    end
  end

  // A locked block always has at least one second left.
  a_locked_secs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ModeLocked) |-> (lock_secs_q != 8'd0))
    else $error("locked with no seconds left");

  // The LED only lights during a lockout.
  a_led_locked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    led_q |-> (mode_q == ModeLocked))
    else $error("LED lit outside lockout");

  // The compared length lies strictly inside the stored entry.
  a_cmp_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    zero_q |-> ((cmp_len_q < entry_q) && (entry_q <= LenW'(MaxEntry))))
    else $error("compare length outside entry");

  // A logout while authenticated returns to awaiting the code.
  a_logout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (op_i == OpLogout) && (mode_q == ModeAuth)) |=>
      ((mode_q == ModeCode) && (entry_q == '0)))
    else $error("logout did not return to code entry");

endmodule

`default_nettype wire

FILE: rtl/access_lock_controller.sv
// Top level: access lock controller with input stage and result register.
//
//   channel  direction  transfer carries
//   in_i     sink       operation, char_code
//   cfg_i    sink       index, data (register write)
//   out_o    source     mode, echo_star, event_res, failure_count, led_level, seconds_left
//
// One item per cycle sustained while out_o.ready stays high; an item's result
// reaches out_o through the input register, then the result register, the lock
// state being updated as the item moves into the result register.
// Reset (rst_ni low) clears the lock state, the configuration to its defaults and
// both stage valids; no clearing pass.
// A stalled result holds in the output register; an empty input stage still takes
// one more item, then in_i.ready drops until the result is taken.
`default_nettype none

module access_lock_controller
  import alc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  alc_in_if.sink    in_i,
  alc_cfg_if.sink   cfg_i,
  alc_out_if.source out_o
);

  // Input stage.
  logic       in_valid_q;
  logic [1:0] op_q;
  logic [7:0] char_q;

  // Result register.
  logic       out_valid_q;
  result_t    res_q;

  logic       advance;
  cfg_t       cfg;
  result_t    res;

  // Item leaves the input stage when the result register is free or emptying.
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  // Writes are always taken; the block is idle by contract when they come.
  assign cfg_i.ready = 1'b1;

  alc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (cfg_i.valid),
    .idx_i  (cfg_i.index),
    .data_i (cfg_i.data),
    .cfg_o  (cfg)
  );

  alc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .op_i   (op_q),
    .char_i (char_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q   <= in_i.operation;
      char_q <= in_i.char_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.mode          = res_q.mode;
  assign out_o.echo_star     = res_q.echo_star;
  assign out_o.event_res     = res_q.event_res;
  assign out_o.failure_count = res_q.failure_count;
  assign out_o.led_level     = res_q.led_level;
  assign out_o.seconds_left  = res_q.seconds_left;

endmodule

`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for access_lock_controller: planned and random items, checked.

module tb;
  import alc_pkg::*;

  // Shadow copy of the lock's registers, at the block's widths.
  typedef struct packed {
    logic [CodeBytes-1:0][7:0] code;
    logic [LenW-1:0]           code_len;
    logic [3:0]                fail_limit;
    logic [7:0]                lock_secs;
    logic [15:0]               window_ms;
    logic [15:0]               debounce_ms;
  } lock_cfg_t;

  // Shadow copy of the lock's state.
  typedef struct packed {
    logic [1:0]         mode;         // ModeOut* encoding
    logic [LenW-1:0]    typed;        // characters stored in the entry
    logic [LenW-1:0]    cmp_len;      // compared length once a zero byte arrived
    logic               zero_seen;
    logic               mismatch;
    logic [3:0]         fails;
    logic [PressW-1:0]  presses;
    logic [15:0]        since_press;  // saturating
    logic [15:0]        confirm_ms;   // saturating
    logic [LockMsW-1:0] lock_ms;
    logic [7:0]         lock_secs;
    logic [BlinkW-1:0]  blink_ms;
    logic               led;
  } lock_state_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] ch;
  } lock_item_t;

  logic clk = 1'b0;
  logic rst_n;

  alc_in_if  in_ch ();
  alc_cfg_if cfg_ch ();
  alc_out_if out_ch ();

  access_lock_controller dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .cfg_i (cfg_ch),
    .out_o (out_ch)
  );

  lock_cfg_t   lock_cfg;    // shared by checker and planner; changes only while idle
  lock_state_t live_lock;   // advanced on each accepted input transfer
  lock_state_t plan_lock;   // advanced as items are queued, steers the stimulus

  lock_item_t  pending_q[$];   // items waiting for the driver
  result_t     awaited_q[$];   // predicted status, oldest first

  logic        in_fired;       // input transfer at the last rising edge
  logic        steady;         // no idling on either side while set
  int unsigned planned;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned lockouts;
  int unsigned grants;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Compared code length: stops at the first zero byte, bytes past the store read as zero.
  function automatic logic [LenW-1:0] code_span(lock_cfg_t c);
    for (int i = 0; i < c.code_len; i++) begin
      if (i >= CodeBytes || c.code[i] == CharNull) return LenW'(i);
    end
    return c.code_len;
  endfunction

  function automatic void wipe_entry(inout lock_state_t s);
    s.typed     = '0;
    s.cmp_len   = '0;
    s.zero_seen = 1'b0;
    s.mismatch  = 1'b0;
  endfunction

  // Any failure bumps the count; reaching the limit turns it into a lockout.
  function automatic event_e count_failure(inout lock_state_t s, input lock_cfg_t c,
                                           input event_e ev);
    if (s.fails != 4'(FailMax)) s.fails = s.fails + 4'd1;
    wipe_entry(s);
    if (s.fails < c.fail_limit) begin
      s.mode = ModeOutCode;
      return ev;
    end
    s.mode      = ModeOutLocked;
    // a lockout of zero seconds still lasts one
    s.lock_secs = (c.lock_secs != 8'd0) ? c.lock_secs : 8'd1;
    s.lock_ms   = '0;
    s.blink_ms  = '0;
    s.led       = 1'b0;
    return EvLocked;
  endfunction

  function automatic result_t advance_lock(inout lock_state_t s, input lock_cfg_t c,
                                           input op_e op, input logic [7:0] ch);
    result_t         r;
    event_e          ev;
    logic            star;
    logic [LenW-1:0] span;
    logic [LenW-1:0] typed_len;
    ev   = EvNone;
    star = 1'b0;
    span = code_span(c);
    case (op)
      OpChar: begin
        // characters outside code entry are dropped without echo
        if (s.mode == ModeOutCode) begin
          if (ch == CharCr) begin
            typed_len = s.zero_seen ? s.cmp_len : s.typed;
            if (!s.mismatch && typed_len == span) begin
              wipe_entry(s);
              s.mode        = ModeOutButton;
              s.presses     = '0;
              s.since_press = '0;
              s.confirm_ms  = '0;
              ev            = EvConfirmAsk;
            end else begin
              ev = count_failure(s, c, EvDenied);
            end
          end else if (s.typed < MaxEntry) begin
            // after a zero byte, characters only add to the length
            if (!s.zero_seen) begin
              if (ch == CharNull) begin
                s.zero_seen = 1'b1;
                s.cmp_len   = s.typed;
              end else if (s.typed >= span || ch != c.code[s.typed]) begin
                s.mismatch = 1'b1;
              end
            end
            s.typed = s.typed + 1'b1;
            star    = 1'b1;
          end else begin
            ev = count_failure(s, c, EvTooLong);
          end
        end
      end
      OpTick: begin
        if (s.since_press != 16'hFFFF) s.since_press = s.since_press + 16'd1;
        if (s.mode == ModeOutButton) begin
          if (s.confirm_ms != 16'hFFFF) s.confirm_ms = s.confirm_ms + 16'd1;
          if (s.confirm_ms >= c.window_ms) ev = count_failure(s, c, EvConfirmFail);
        end else if (s.mode == ModeOutLocked) begin
          s.lock_ms = s.lock_ms + 1'b1;
          if (s.lock_ms >= TicksPerSecond) begin
            s.lock_ms = '0;
            if (s.lock_secs != 8'd0) s.lock_secs = s.lock_secs - 8'd1;
          end
          if (s.lock_secs == 8'd0) begin
            // lockout over: the failure count starts afresh
            s.mode     = ModeOutCode;
            s.fails    = '0;
            wipe_entry(s);
            s.led      = 1'b0;
            s.blink_ms = '0;
            s.lock_ms  = '0;
            ev         = EvUnlocked;
          end else begin
            s.blink_ms = s.blink_ms + 1'b1;
            if (s.blink_ms >= BlinkHalfMs) begin
              s.blink_ms = '0;
              s.led      = ~s.led;
            end
          end
        end
      end
      OpPress: begin
        // debounce runs in every mode, presses only count while confirming
        if (s.since_press >= c.debounce_ms) begin
          s.since_press = '0;
          if (s.mode == ModeOutButton) begin
            if (s.presses < PressesNeeded) s.presses = s.presses + 1'b1;
            if (s.presses >= PressesNeeded) begin
              s.mode = ModeOutAuth;
              ev     = EvGranted;
            end
          end
        end
      end
      default: begin
        if (s.mode == ModeOutAuth) begin
          s.mode = ModeOutCode;
          wipe_entry(s);
          ev = EvLoggedOut;
        end
      end
    endcase
    r               = '0;
    r.mode          = s.mode;
    r.echo_star     = star;
    r.event_res     = ev;
    r.failure_count = s.fails;
    r.led_level     = s.led;
    r.seconds_left  = (s.mode == ModeOutLocked) ? s.lock_secs : 8'd0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one item per transfer, random gaps between items. Outputs move on the
  // falling edge so the rising edge always sees settled values.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    lock_item_t nxt;
    if (!in_ch.valid || in_fired) begin
      if (rst_n && pending_q.size() != 0 && (steady || $urandom_range(0, 99) >= 30)) begin
        nxt = pending_q.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.operation <= nxt.op;
        in_ch.char_code <= nxt.ch;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    in_fired = 1'b0;
    out_ch.ready <= steady || ($urandom_range(0, 99) >= 30);
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: predicts on each input transfer, checks each result transfer
  // against the oldest prediction. The input side goes first in case both
  // transfers land on the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        awaited_q.push_back(advance_lock(live_lock, lock_cfg, op_e'(in_ch.operation),
                                         in_ch.char_code));
        in_fired = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.mode          = out_ch.mode;
        got.echo_star     = out_ch.echo_star;
        got.event_res     = out_ch.event_res;
        got.failure_count = out_ch.failure_count;
        got.led_level     = out_ch.led_level;
        got.seconds_left  = out_ch.seconds_left;
        results_seen++;
        if (awaited_q.size() == 0) begin
          $error("result transfer with no prediction outstanding");
          mismatches++;
        end else begin
          want = awaited_q.pop_front();
          check_field("mode", want.mode, got.mode);
          check_field("echo_star", want.echo_star, got.echo_star);
          check_field("event_res", want.event_res, got.event_res);
          check_field("failure_count", want.failure_count, got.failure_count);
          check_field("led_level", want.led_level, got.led_level);
          check_field("seconds_left", want.seconds_left, got.seconds_left);
          if (want.event_res == EvLocked) lockouts++;
          if (want.event_res == EvGranted) grants++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration writes, only issued while the lock is idle
  // ---------------------------------------------------------------------------

  // Fill the unused upper bits with junk; the block must ignore them.
  function automatic logic [63:0] pad_junk(logic [63:0] v, int unsigned w);
    logic [63:0] keep;
    keep = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    return ({$urandom, $urandom} & ~keep) | (v & keep);
  endfunction

  // Called on a falling edge, returns on a falling edge.
  task automatic write_reg(cfg_reg_e idx, logic [63:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      RegCodeLow:    lock_cfg.code[7:0]   = value;
      RegCodeMid:    lock_cfg.code[15:8]  = value;
      RegCodeHigh:   lock_cfg.code[18:16] = value[23:0];
      RegCodeLength: lock_cfg.code_len    = value[LenW-1:0];
      RegFailLimit:  lock_cfg.fail_limit  = value[3:0];
      RegLockSecs:   lock_cfg.lock_secs   = value[7:0];
      RegConfirmWin: lock_cfg.window_ms   = value[15:0];
      default:       lock_cfg.debounce_ms = value[15:0];
    endcase
    @(negedge clk);
  endtask

  task automatic load_settings(lock_cfg_t c);
    write_reg(RegCodeLow, c.code[7:0]);
    write_reg(RegCodeMid, c.code[15:8]);
    write_reg(RegCodeHigh, pad_junk(64'(c.code[18:16]), 24));
    write_reg(RegCodeLength, pad_junk(64'(c.code_len), LenW));
    write_reg(RegFailLimit, pad_junk(64'(c.fail_limit), 4));
    write_reg(RegLockSecs, pad_junk(64'(c.lock_secs), 8));
    write_reg(RegConfirmWin, pad_junk(64'(c.window_ms), 16));
    write_reg(RegDebounce, pad_junk(64'(c.debounce_ms), 16));
    cfg_ch.valid <= 1'b0;
  endtask

  // Waits until every queued item is taken and every result checked.
  task automatic wait_idle();
    do @(negedge clk); while (pending_q.size() != 0 || in_ch.valid || awaited_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus planning. Items are queued in zero time; the planner runs its own
  // copy of the lock state so it knows which mode the block will be in.
  // ---------------------------------------------------------------------------

  // Ticks that only wait out a lockout are not counted towards the item budget.
  function automatic result_t plan_item(op_e op, logic [7:0] ch);
    lock_item_t it;
    if (!(op == OpTick && plan_lock.mode == ModeOutLocked)) planned++;
    it.op = op;
    it.ch = ch;
    pending_q.push_back(it);
    return advance_lock(plan_lock, lock_cfg, op, ch);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] any_but_cr();
    logic [7:0] ch;
    ch = rand_byte();
    return (ch == CharCr) ? ~CharCr : ch;
  endfunction

  function automatic logic [CodeBytes-1:0][7:0] random_code();
    logic [CodeBytes-1:0][7:0] b;
    for (int i = 0; i < CodeBytes; i++) b[i] = rand_byte();
    return b;
  endfunction

  // One burst of items suited to the mode the lock will be in.
  function automatic void plan_burst();
    int unsigned     r;
    int unsigned     n;
    int unsigned     dbn;
    logic [7:0]      entry[$];
    logic [LenW-1:0] span;
    result_t         res;
    r = $urandom_range(0, 99);
    case (plan_lock.mode)
      ModeOutCode: begin
        span = code_span(lock_cfg);
        if (r < 50) begin
          // the right code, in about half the cases spoilt in one of several ways
          for (int i = 0; i < span; i++) entry.push_back(lock_cfg.code[i]);
          case ($urandom_range(0, 5))
            0: if (entry.size() != 0)
                 entry[$urandom_range(0, entry.size() - 1)] = rand_byte();
            1: entry.push_back(any_but_cr());
            2: begin
              // zero byte ends the compared text, the tail only adds length
              entry.push_back(CharNull);
              repeat ($urandom_range(0, 3)) entry.push_back(any_but_cr());
            end
            3: if (entry.size() != 0) void'(entry.pop_back());
            default: ;
          endcase
          foreach (entry[i]) void'(plan_item(OpChar, entry[i]));
          void'(plan_item(OpChar, CharCr));
        end else if (r < 65) begin
          repeat ($urandom_range(0, 5)) void'(plan_item(OpChar, rand_byte()));
          void'(plan_item(OpChar, CharCr));
        end else if (r < 72) begin
          // overlong entry: keep typing until the block rejects it
          n = 0;
          do begin
            res = plan_item(OpChar, any_but_cr());
            n++;
          end while (res.event_res == EvNone && n < 25);
        end else begin
          void'(plan_item(op_e'($urandom_range(0, 3)), rand_byte()));
        end
      end
      ModeOutButton: begin
        if (r < 10) begin
          // let the confirmation window run out
          n = 0;
          while (plan_lock.mode == ModeOutButton && n < 70000) begin
            void'(plan_item(OpTick, rand_byte()));
            n++;
          end
        end else if (r < 18) begin
          void'(plan_item(op_e'($urandom_range(0, 3)), rand_byte()));
        end else begin
          // with a short debounce, press roughly at its boundary, either side of it
          dbn = (lock_cfg.debounce_ms > 16'd10) ? 3 : lock_cfg.debounce_ms;
          repeat ($urandom_range(0, dbn + 2)) void'(plan_item(OpTick, rand_byte()));
          void'(plan_item(OpPress, rand_byte()));
        end
      end
      ModeOutAuth: begin
        if (r < 65) void'(plan_item(OpLogout, rand_byte()));
        else void'(plan_item(op_e'($urandom_range(0, 3)), rand_byte()));
      end
      default: begin
        while (plan_lock.mode == ModeOutLocked)
          void'(plan_item(OpTick, rand_byte()));
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------
  initial begin
    lock_cfg_t   c;
    int unsigned goal;

    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OpChar;
    in_ch.char_code = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = RegCodeLow;
    cfg_ch.data     = '0;
    out_ch.ready    = 1'b0;
    in_fired        = 1'b0;
    steady          = 1'b0;
    planned         = 0;
    results_seen    = 0;
    mismatches      = 0;
    lockouts        = 0;
    grants          = 0;

    // register values after reset
    lock_cfg             = '0;
    lock_cfg.code_len    = LenW'(12);
    lock_cfg.fail_limit  = 4'd3;
    lock_cfg.lock_secs   = 8'd30;
    lock_cfg.window_ms   = 16'd10000;
    lock_cfg.debounce_ms = 16'd200;
    live_lock            = '0;   // zero mode is awaiting code
    plan_lock            = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part: two-byte code 0xFF 0x01, no debounce, the widest window.
    c             = lock_cfg;
    c.code        = random_code();
    c.code[0]     = 8'hFF;
    c.code[1]     = 8'h01;
    c.code_len    = LenW'(2);
    c.fail_limit  = 4'd2;
    c.lock_secs   = 8'd0;
    c.window_ms   = 16'hFFFF;
    c.debounce_ms = 16'd0;
    load_settings(c);
    void'(plan_item(OpLogout, 8'h00));   // logout while not logged in: ignored
    void'(plan_item(OpPress, 8'hFF));    // press outside confirmation: not counted
    void'(plan_item(OpTick, 8'h00));
    void'(plan_item(OpChar, 8'hFF));
    void'(plan_item(OpChar, 8'h01));
    void'(plan_item(OpChar, CharCr));    // match, confirmation asked
    repeat (3) void'(plan_item(OpPress, 8'h00));
    void'(plan_item(OpChar, 8'h41));     // characters ignored once authenticated
    void'(plan_item(OpLogout, 8'h00));
    void'(plan_item(OpChar, 8'hFF));     // zero byte cuts the compare short: denied
    void'(plan_item(OpChar, CharNull));
    void'(plan_item(OpChar, 8'h55));
    void'(plan_item(OpChar, CharCr));
    void'(plan_item(OpChar, 8'hFF));     // full code then zero byte and tail: match
    void'(plan_item(OpChar, 8'h01));
    void'(plan_item(OpChar, CharNull));
    void'(plan_item(OpChar, 8'h77));
    void'(plan_item(OpChar, CharCr));
    void'(plan_item(OpTick, 8'hAA));
    repeat (3) void'(plan_item(OpPress, 8'h55));
    void'(plan_item(OpLogout, 8'hFF));
    wait_idle();

    // Random part: the first two settings sit at the extremes, the rest are random
    // with short codes and short windows so that every mode is reached often.
    for (int p = 0; p < 8; p++) begin
      c      = lock_cfg;
      c.code = random_code();
      case (p)
        0: begin
          // empty code, any failure locks, zero-second lockout, window closes at once
          c.code_len    = '0;
          c.fail_limit  = 4'd0;
          c.lock_secs   = 8'd0;
          c.window_ms   = 16'd0;
          c.debounce_ms = 16'd0;
        end
        1: begin
          // longest code of all 0xFF bytes; presses never clear the debounce
          c.code        = '1;
          c.code_len    = '1;
          c.fail_limit  = 4'd15;
          c.lock_secs   = 8'd1;
          c.window_ms   = 16'd40;
          c.debounce_ms = 16'hFFFF;
        end
        default: begin
          if ($urandom_range(0, 3) == 0) c.code[$urandom_range(0, CodeBytes - 1)] = CharNull;
          c.code_len    = ($urandom_range(0, 9) < 7) ? LenW'($urandom_range(1, 6))
                                                     : LenW'($urandom_range(0, 31));
          c.fail_limit  = 4'($urandom_range(1, 5));
          c.lock_secs   = 8'($urandom_range(0, 1));
          c.window_ms   = 16'($urandom_range(8, 60));
          c.debounce_ms = 16'($urandom_range(0, 6));
        end
      endcase
      steady = (p == 3);   // one whole phase with no gaps on either side
      load_settings(c);
      goal = planned + 66;
      while (planned < goal) plan_burst();
      while (plan_lock.mode != ModeOutCode) plan_burst();
      wait_idle();
    end
    steady = 1'b0;

    // Longest lockout: lock once and watch two seconds count down with the LED blinking.
    c             = lock_cfg;
    c.code_len    = LenW'(1);
    c.fail_limit  = 4'd1;
    c.lock_secs   = 8'hFF;
    c.window_ms   = 16'hFFFF;
    c.debounce_ms = 16'd5;
    load_settings(c);
    void'(plan_item(OpChar, ~lock_cfg.code[0]));
    void'(plan_item(OpChar, CharCr));
    repeat (2100) void'(plan_item(OpTick, rand_byte()));
    wait_idle();

    $display("Checked %0d results over ten register settings: %0d grants, %0d lockouts.",
             results_seen, grants, lockouts);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #100_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
